// ----- design/crhm_pkg.sv -----
`timescale 1ns / 1ps

package crhm_pkg;

	localparam int DEPTH_W = 16;
	localparam int EXT_W   = 16;
	localparam int HR_W    = 12;
	localparam int COL_W   = 11;
	localparam int CNT_W   = 24;
	localparam int NUM_W   = EXT_W + HR_W + 2;
	localparam int DEN_W   = DEPTH_W + 1;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] REG_DEPTH_MAX = 2'd0;
	localparam logic [1:0] REG_EXTENT    = 2'd1;
	localparam logic [1:0] REG_HALF_ROWS = 2'd2;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_max;
		logic [EXT_W-1:0]   model_extent;
		logic [HR_W-1:0]    half_rows;
	} cfg_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] d;
		logic [COL_W-1:0]   col;
		logic               first;
	} tag_t;

endpackage

// ----- design/crhm_ram.sv -----
`timescale 1ns / 1ps

module crhm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic                               re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/crhm_cfg.sv -----
`timescale 1ns / 1ps

module crhm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crhm_pkg::APB_AW-1:0]   paddr,
	input  logic [crhm_pkg::APB_DW-1:0]   pwdata,
	output logic [crhm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output crhm_pkg::cfg_t                cfg
);

	crhm_pkg::cfg_t cfg_q;
	logic [1:0]     idx;
	logic           wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_max    <= crhm_pkg::DEPTH_W'(65535);
			cfg_q.model_extent <= crhm_pkg::EXT_W'(1000);
			cfg_q.half_rows    <= crhm_pkg::HR_W'(240);
		end else if (wr) begin
			case (idx)
				crhm_pkg::REG_DEPTH_MAX: cfg_q.depth_max    <= pwdata[crhm_pkg::DEPTH_W-1:0];
				crhm_pkg::REG_EXTENT:    cfg_q.model_extent <= pwdata[crhm_pkg::EXT_W-1:0];
				crhm_pkg::REG_HALF_ROWS: cfg_q.half_rows    <= pwdata[crhm_pkg::HR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			crhm_pkg::REG_DEPTH_MAX: prdata = crhm_pkg::APB_DW'(cfg_q.depth_max);
			crhm_pkg::REG_EXTENT:    prdata = crhm_pkg::APB_DW'(cfg_q.model_extent);
			crhm_pkg::REG_HALF_ROWS: prdata = crhm_pkg::APB_DW'(cfg_q.half_rows);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- design/crhm_div.sv -----
`timescale 1ns / 1ps

module crhm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [crhm_pkg::NUM_W-1:0]  in_num,
	input  logic [crhm_pkg::DEN_W-1:0]  in_den,
	input  crhm_pkg::tag_t              in_tag,
	output logic                        out_v,
	output logic [crhm_pkg::NUM_W-1:0]  out_q,
	output crhm_pkg::tag_t              out_tag
);

	localparam int N  = crhm_pkg::NUM_W;
	localparam int DW = crhm_pkg::DEN_W;

	logic                 v_s   [N];
	logic [DW-1:0]        rem_s [N];
	logic [N-1:0]         num_s [N];
	logic [N-1:0]         quo_s [N];
	logic [DW-1:0]        den_s [N];
	crhm_pkg::tag_t       tag_s [N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_st
			logic           pv;
			logic [DW-1:0]  prem;
			logic [N-1:0]   pnum;
			logic [N-1:0]   pquo;
			logic [DW-1:0]  pden;
			crhm_pkg::tag_t ptag;
			logic [DW:0]    trial;
			logic           ge;

			if (i == 0) begin : g_first
				assign pv   = in_v;
				assign prem = '0;
				assign pnum = in_num;
				assign pquo = '0;
				assign pden = in_den;
				assign ptag = in_tag;
			end else begin : g_next
				assign pv   = v_s[i-1];
				assign prem = rem_s[i-1];
				assign pnum = num_s[i-1];
				assign pquo = quo_s[i-1];
				assign pden = den_s[i-1];
				assign ptag = tag_s[i-1];
			end

			assign trial = {prem, pnum[N-1]};
			assign ge    = trial >= {1'b0, pden};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (en) begin
					v_s[i] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? DW'(trial - {1'b0, pden}) : DW'(trial);
					num_s[i] <= {pnum[N-2:0], 1'b0};
					quo_s[i] <= {pquo[N-2:0], ge};
					den_s[i] <= pden;
					tag_s[i] <= ptag;
				end
			end
		end
	endgenerate

	assign out_v   = v_s[N-1];
	assign out_q   = quo_s[N-1];
	assign out_tag = tag_s[N-1];

	a_rem_lt_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] && den_s[N-1] != '0 |-> rem_s[N-1] < den_s[N-1])
		else $error("divider remainder not below divisor");

endmodule

// ----- design/column_range_hold_min_top.sv -----
`timescale 1ns / 1ps

// Per-column vertical hold-minimum filter for a range map. One pixel per clock in
// raster order while the output is not stalled; each result passes through one input
// stage, the 30-stage restoring divider that computes the hold length for every pixel,
// one column-memory read stage and the output register, in that order. A stalled
// output holds the whole pipeline.
// Column state lives in one MAX_COLS-entry memory with a one-deep write-back
// forward; it is undefined until the column sees a first-row pixel.
module column_range_hold_min_top #(
	parameter int MAX_COLS   = 2048,
	parameter int DEPTH_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crhm_pkg::APB_AW-1:0]   paddr,
	input  logic [crhm_pkg::APB_DW-1:0]   pwdata,
	output logic [crhm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [DEPTH_BITS-1:0]         depth,
	input  logic [crhm_pkg::COL_W-1:0]    column,
	input  logic                          first_row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crhm_pkg::DEPTH_W-1:0]  held_depth
);

	localparam int DW     = crhm_pkg::DEPTH_W;
	localparam int CW     = crhm_pkg::CNT_W;
	localparam int AW     = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int XW     = AW > crhm_pkg::COL_W ? AW : crhm_pkg::COL_W;
	localparam int RW     = DW + CW;
	localparam int CMPW   = DEPTH_BITS > DW ? DEPTH_BITS : DW;

	crhm_pkg::cfg_t cfg;
	logic           adv;

	crhm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic out_valid_q;
	logic [DW-1:0] held_depth_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign held_depth = held_depth_q;

	// input stage: clip, hold-length numerator
	logic [CMPW-1:0] raw_x;
	logic [DW-1:0]   dclip;
	logic [DW-1:0]   dfin;

	assign raw_x = CMPW'(depth);
	assign dclip = (raw_x > CMPW'(cfg.depth_max)) ? cfg.depth_max : raw_x[DW-1:0];
	assign dfin  = (dclip == '0) ? cfg.depth_max : dclip;

	logic                        v_s1;
	logic [crhm_pkg::NUM_W-1:0]  num_s1;
	crhm_pkg::tag_t              tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= ((crhm_pkg::NUM_W'(cfg.model_extent)
				* crhm_pkg::NUM_W'(cfg.half_rows)) << 1)
				+ crhm_pkg::NUM_W'(dfin);
			tag_s1.d     <= dfin;
			tag_s1.col   <= column;
			tag_s1.first <= first_row;
		end
	end

	logic                        v_dv;
	logic [crhm_pkg::NUM_W-1:0]  q_dv;
	crhm_pkg::tag_t              tag_dv;

	crhm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (v_s1),
		.in_num  (num_s1),
		.in_den  ({tag_s1.d, 1'b0}),
		.in_tag  (tag_s1),
		.out_v   (v_dv),
		.out_q   (q_dv),
		.out_tag (tag_dv)
	);

	// memory read stage
	logic [XW-1:0] colx_dv;
	logic          oor_dv;
	logic [CW-1:0] hl_dv;

	assign colx_dv = XW'(tag_dv.col);
	assign oor_dv  = 32'(tag_dv.col) >= MAX_COLS;
	assign hl_dv   = (tag_dv.d == '0 || q_dv > crhm_pkg::NUM_W'(crhm_pkg::COUNT_MAX))
		? crhm_pkg::COUNT_MAX : q_dv[CW-1:0];

	logic          v_r;
	logic [DW-1:0] d_r;
	logic [AW-1:0] addr_r;
	logic          oor_r;
	logic          first_r;
	logic [CW-1:0] hl_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r <= 1'b0;
		end else if (adv) begin
			v_r <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_r     <= tag_dv.d;
			addr_r  <= colx_dv[AW-1:0];
			oor_r   <= oor_dv;
			first_r <= tag_dv.first;
			hl_r    <= hl_dv;
		end
	end

	logic          ram_we;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;

	crhm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_COLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_r),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (colx_dv[AW-1:0]),
		.rdata (ram_rdata)
	);

	// update stage with forward of the write made alongside this read
	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [RW-1:0] fwd_data_q;
	logic [RW-1:0] cur;
	logic [DW-1:0] held_in;
	logic [CW-1:0] cnt_in;
	logic [DW-1:0] held_mid;
	logic [CW-1:0] cnt_mid;
	logic [DW-1:0] held_nx;
	logic [CW-1:0] cnt_nx;

	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_r) begin
			cur = fwd_data_q;
		end else begin
			cur = ram_rdata;
		end
		if (first_r) begin
			held_in = cfg.depth_max;
			cnt_in  = '0;
		end else begin
			held_in = cur[RW-1:CW];
			cnt_in  = cur[CW-1:0];
		end
		if (d_r < held_in) begin
			held_mid = d_r;
			cnt_mid  = hl_r;
		end else begin
			held_mid = held_in;
			cnt_mid  = cnt_in;
		end
		if (cnt_mid <= CW'(1)) begin
			held_nx = d_r;
			cnt_nx  = '0;
		end else begin
			held_nx = held_mid;
			cnt_nx  = cnt_mid - CW'(1);
		end
	end

	assign ram_we    = adv && v_r && !oor_r;
	assign ram_wdata = {held_nx, cnt_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			fwd_valid_q <= v_r && !oor_r;
			out_valid_q <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q   <= addr_r;
			fwd_data_q   <= ram_wdata;
			held_depth_q <= oor_r ? d_r : held_nx;
		end
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction lost at input stage");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_r && adv |=> out_valid_q)
		else $error("update stage transaction not delivered");

	a_held_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		v_r |-> held_nx <= d_r)
		else $error("held depth above current depth");

endmodule
